// ----- rtl/lkvc_pkg.sv -----
`default_nettype none

package lkvc_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes of the input channel.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Value returned by a get that misses.
  localparam logic signed [DATA_W-1:0] MISS_DATA = -32'sd1;

endpackage

`default_nettype wire

// ----- rtl/lkvc_channels.sv -----
`default_nettype none

// Request channel: one get or put per transaction.
interface lkvc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [lkvc_pkg::KEY_W-1:0]   key;
  logic signed [lkvc_pkg::DATA_W-1:0]  data_in;

  modport source (output valid, output op, output key, output data_in, input ready);
  modport sink   (input valid, input op, input key, input data_in, output ready);
endinterface

// Response channel: one transaction per get.
interface lkvc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic signed [lkvc_pkg::DATA_W-1:0]  data_out;

  modport source (output valid, output found, output data_out, input ready);
  modport sink   (input valid, input found, input data_out, output ready);
endinterface

// Configuration channel carrying the capacity register.
interface lkvc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lkvc_pkg::CAP_W-1:0]   capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ----- rtl/lkvc_store.sv -----
`default_nettype none

// Single-port-write, single-port-read entry memory with a registered read.
module lkvc_store #(
  parameter int ENTRIES = 16,
  parameter int WORD_W  = 69,
  localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [WORD_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/lkvc_ctrl.sv -----
`default_nettype none

// Sequencer: a scan pass over every entry, a decision step, and for most
// requests a read-modify-write pass that rewrites ranks, key and value.
module lkvc_ctrl #(
  parameter int ENTRIES = 16,
  localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CW     = $clog2(ENTRIES + 1),
  localparam int WORD_W = 1 + AW + lkvc_pkg::KEY_W + lkvc_pkg::DATA_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  lkvc_in_if.sink                         in_ch,
  lkvc_out_if.source                      out_ch,
  input  wire logic [lkvc_pkg::CAP_W-1:0] capacity,
  output logic                            mem_rd_en,
  output logic      [AW-1:0]              mem_rd_addr,
  input  wire logic [WORD_W-1:0]          mem_rd_data,
  output logic                            mem_wr_en,
  output logic      [AW-1:0]              mem_wr_addr,
  output logic      [WORD_W-1:0]          mem_wr_data
);

  typedef struct packed {
    logic                          valid;
    logic [AW-1:0]                 rank;
    logic [lkvc_pkg::KEY_W-1:0]    key;
    logic [lkvc_pkg::DATA_W-1:0]   data;
  } entry_t;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_t;

  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               addr_r, addr_nxt;
  logic                        issue_r, issue_nxt;
  logic                        rv_r, rv_nxt;
  logic [AW-1:0]               ridx_r, ridx_nxt;
  logic                        op_r, op_nxt;
  logic [lkvc_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [lkvc_pkg::DATA_W-1:0] din_r, din_nxt;
  logic                        hit_r, hit_nxt;
  logic [AW-1:0]               hit_idx_r, hit_idx_nxt;
  logic [AW-1:0]               hit_rank_r, hit_rank_nxt;
  logic [lkvc_pkg::DATA_W-1:0] hit_data_r, hit_data_nxt;
  logic                        free_ok_r, free_ok_nxt;
  logic [AW-1:0]               free_idx_r, free_idx_nxt;
  logic [AW-1:0]               lru1_r, lru1_nxt;
  logic [AW-1:0]               lru2_r, lru2_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]               tgt_r, tgt_nxt;
  logic                        ev_en_r, ev_en_nxt;
  logic [AW-1:0]               ev_idx_r, ev_idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [lkvc_pkg::DATA_W-1:0] out_data_r, out_data_nxt;

  entry_t        rd_ent;
  entry_t        wr_ent;
  logic [CW-1:0] eff_cap;
  logic          full;
  logic          walking;
  logic          out_free;

  assign rd_ent   = entry_t'(mem_rd_data);
  assign full     = (cnt_r == CW'(ENTRIES));
  assign walking  = (state_r == ST_SCAN) || (state_r == ST_UPDATE);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (int'(capacity) > ENTRIES) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.data_out = out_data_r;

  assign mem_rd_en   = walking && issue_r;
  assign mem_rd_addr = addr_r;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    rv_nxt        = walking && issue_r;
    ridx_nxt      = addr_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    din_nxt       = din_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    hit_data_nxt  = hit_data_r;
    free_ok_nxt   = free_ok_r;
    free_idx_nxt  = free_idx_r;
    lru1_nxt      = lru1_r;
    lru2_nxt      = lru2_r;
    cnt_nxt       = cnt_r;
    tgt_nxt       = tgt_r;
    ev_en_nxt     = ev_en_r;
    ev_idx_nxt    = ev_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_data_nxt  = out_data_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = ridx_r;
    wr_ent        = rd_ent;

    if (walking && issue_r) begin
      if (addr_r == LAST) begin
        issue_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + AW'(1);
      end
    end

    case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_r;
        wr_ent      = '0;
        if (addr_r == LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt      = in_ch.op;
          key_nxt     = in_ch.key;
          din_nxt     = in_ch.data_in;
          hit_nxt     = 1'b0;
          free_ok_nxt = 1'b0;
          addr_nxt    = '0;
          issue_nxt   = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (rv_r) begin
          if (rd_ent.valid && (rd_ent.key == key_r) && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = ridx_r;
            hit_rank_nxt = rd_ent.rank;
            hit_data_nxt = rd_ent.data;
          end
          if (!rd_ent.valid && !free_ok_r) begin
            free_ok_nxt  = 1'b1;
            free_idx_nxt = ridx_r;
          end
          if (rd_ent.valid && (CW'(rd_ent.rank) == cnt_r - CW'(1))) begin
            lru1_nxt = ridx_r;
          end
          if (rd_ent.valid && (CW'(rd_ent.rank) == cnt_r - CW'(2))) begin
            lru2_nxt = ridx_r;
          end
          if (ridx_r == LAST) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        addr_nxt  = '0;
        if (op_r == lkvc_pkg::OP_GET) begin
          ev_en_nxt = 1'b0;
          tgt_nxt   = hit_idx_r;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = hit_r;
            out_data_nxt  = hit_r ? hit_data_r : lkvc_pkg::MISS_DATA;
            issue_nxt     = hit_r;
            state_nxt     = hit_r ? ST_UPDATE : ST_IDLE;
          end
        end else begin
          issue_nxt = 1'b1;
          state_nxt = ST_UPDATE;
          if (hit_r) begin
            // Update in place; after the touch the oldest entry is the one
            // ranked last, or the one ranked second last if the hit was last.
            tgt_nxt    = hit_idx_r;
            ev_en_nxt  = (cnt_r > eff_cap);
            ev_idx_nxt = (CW'(hit_rank_r) == cnt_r - CW'(1)) ? lru2_r : lru1_r;
            cnt_nxt    = cnt_r - CW'(ev_en_nxt);
          end else if (full) begin
            // Full store: the oldest entry is replaced by the new key.
            tgt_nxt    = lru1_r;
            ev_en_nxt  = (cnt_r > eff_cap);
            ev_idx_nxt = lru2_r;
            cnt_nxt    = cnt_r - CW'(ev_en_nxt);
          end else begin
            tgt_nxt    = free_idx_r;
            ev_en_nxt  = (cnt_r >= eff_cap);
            ev_idx_nxt = lru1_r;
            cnt_nxt    = cnt_r + CW'(1) - CW'(ev_en_nxt);
          end
        end
      end

      ST_UPDATE: begin
        if (rv_r) begin
          mem_wr_en = 1'b1;
          if (ev_en_r && (ridx_r == ev_idx_r)) begin
            wr_ent.valid = 1'b0;
            wr_ent.rank  = '0;
          end else if (ridx_r == tgt_r) begin
            wr_ent.valid = 1'b1;
            wr_ent.rank  = '0;
            if (op_r == lkvc_pkg::OP_PUT) begin
              wr_ent.data = din_r;
            end
            if (!hit_r) begin
              wr_ent.key = key_r;
            end
          end else if (rd_ent.valid && (!hit_r || (rd_ent.rank < hit_rank_r))) begin
            wr_ent.rank = rd_ent.rank + AW'(1);
          end
          if (ridx_r == LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign mem_wr_data = wr_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      issue_r     <= 1'b0;
      rv_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      issue_r     <= issue_nxt;
      rv_r        <= rv_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r      <= ridx_nxt;
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    din_r       <= din_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    hit_data_r  <= hit_data_nxt;
    free_ok_r   <= free_ok_nxt;
    free_idx_r  <= free_idx_nxt;
    lru1_r      <= lru1_nxt;
    lru2_r      <= lru2_nxt;
    tgt_r       <= tgt_nxt;
    ev_en_r     <= ev_en_nxt;
    ev_idx_r    <= ev_idx_nxt;
    out_found_r <= out_found_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/lru_key_value_cache_unit.sv -----
// A get result is presented after the scan pass, once the reply register is free.
// A new request is taken only when the previous one is finished. A get that misses
// needs one walk; every other request needs two walks through the single-read-port entry memory.
// Reset: synchronous, active low; afterwards a clearing pass over every entry empties
// the entry memory, during which no request is taken. Capacity resets to 16.
`default_nettype none

module lru_key_value_cache_unit #(
  parameter int ENTRIES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lkvc_in_if.sink    in_ch,
  lkvc_out_if.source out_ch,
  lkvc_cfg_if.sink   cfg_ch
);

  localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_W = 1 + AW + lkvc_pkg::KEY_W + lkvc_pkg::DATA_W;

  // The capacity register. Writes are always taken; the contract is that
  // they only arrive while no request is in flight.
  logic [lkvc_pkg::CAP_W-1:0] cap_r, cap_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cap_nxt      = cfg_ch.valid ? cfg_ch.capacity : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // Each entry word holds a valid bit, a recency rank (zero is the most
  // recent), the key and the value. Valid entries always carry the distinct
  // ranks from zero up to the entry count less one, which lets the sequencer
  // locate the oldest entry by its rank during the scan.
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [WORD_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;

  // The sequencer walks the memory twice per request, but once for a get that misses.
  // The scan finds the matching entry, the first empty slot and the two oldest entries.
  // The update pass then reads each entry and writes it back in the following cycle, so
  // the write always trails the read by one address and never meets it.
  lkvc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .capacity    (cap_r),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  lkvc_store #(
    .ENTRIES (ENTRIES),
    .WORD_W  (WORD_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

`default_nettype wire

// ----- tb/lru_key_value_cache_unit_tb.sv -----
`default_nettype none

module lru_key_value_cache_unit_tb;

  // Number of slots in the cache under test.
  localparam int ENTRIES = 16;

  // A put gives no reply. So once the last reply has arrived, the block may still be busy
  // with a put. The settling wait is made long enough to cover such a put.
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;

  // The slowest correct run is roughly 1450 requests, plus the random gaps on both sides
  // and the long stalls on the reply side. This limit is several times the length of that
  // run and also covers the clearing pass that follows reset.
  localparam int unsigned CYCLE_LIMIT = 800_000;

  // One expected reply to a get.
  typedef struct {
    logic                               found;
    logic signed [lkvc_pkg::DATA_W-1:0] data;
  } cache_reply_t;

  logic clk;
  logic rst_n;

  lkvc_in_if  in_if ();
  lkvc_out_if out_if ();
  lkvc_cfg_if cfg_if ();

  lru_key_value_cache_unit #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  // The testbench keeps its own copy of the cache contents. Each slot has a valid flag,
  // a key, a value and a recency rank, where rank 0 marks the most recent entry.
  logic                        slot_used [ENTRIES];
  logic [lkvc_pkg::KEY_W-1:0]  slot_key  [ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] slot_data [ENTRIES];
  int unsigned                 slot_rank [ENTRIES];
  int unsigned                 used_count;
  logic [lkvc_pkg::CAP_W-1:0]  cap_setting;

  // Replies that the block still owes, oldest first.
  cache_reply_t replies_due[$];

  // Keys that the random traffic draws from, so that lookups often hit.
  logic [lkvc_pkg::KEY_W-1:0] key_pool [32];

  int          send_idle_pct;
  int          recv_idle_pct;
  int          result_hold;
  int          error_count;
  int          requests_sent;
  int          gets_sent;
  int          replies_checked;
  int          hits_seen;
  int unsigned cycle_count;

  // The clock has a period of 12 time units, and its first rising edge comes at time 6.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // This is the watchdog. A hung handshake ends the run here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[lru_key_value_cache_unit] ERROR");
      $finish;
    end
  end

  // This process drives the reply side. A long hold-off, when one is requested, takes
  // priority over the random idling. The length of the hold-off is counted down here,
  // one cycle at a time.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (result_hold > 0) begin
      out_if.ready <= 1'b0;
      result_hold--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every reply transaction is compared with the oldest expectation in the queue. The
  // handshake signals read here hold their values from before the edge, since all
  // updates take place in the nonblocking region.
  always @(posedge clk) begin
    cache_reply_t due;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        $error("reply with nothing outstanding: found %0b, data_out %0d",
               out_if.found, out_if.data_out);
        error_count++;
      end else begin
        due = replies_due.pop_front();
        replies_checked++;
        if (due.found) hits_seen++;
        if (out_if.found !== due.found) begin
          $error("found mismatch: expected %0b, actual %0b", due.found, out_if.found);
          error_count++;
        end
        if (out_if.data_out !== due.data) begin
          $error("data_out mismatch: expected %0d, actual %0d", due.data, out_if.data_out);
          error_count++;
        end
      end
    end
  end

  // This makes slot s the most recent. Entries that were more recent than s age by one.
  function automatic void promote_slot(int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  // This drops the least recent entry, which is the one whose rank equals count - 1.
  function automatic void evict_oldest();
    if (used_count == 0) return;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_rank[i] == used_count - 1) begin
        slot_used[i] = 1'b0;
        slot_rank[i] = 0;
        used_count--;
        return;
      end
    end
  endfunction

  // This applies one request to the copy of the cache. It returns 1 when the request is
  // a get, and then fills in the reply that the block must give.
  function automatic bit predict_access(input logic op,
                                        input logic [lkvc_pkg::KEY_W-1:0] k,
                                        input logic [lkvc_pkg::DATA_W-1:0] v,
                                        output cache_reply_t reply);
    int hit_slot;
    int free_slot;
    int unsigned cap_eff;
    hit_slot  = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_slot < 0 && slot_used[i] && slot_key[i] == k) hit_slot = i;
    end

    if (op == lkvc_pkg::OP_GET) begin
      if (hit_slot >= 0) begin
        promote_slot(hit_slot);
        reply.found = 1'b1;
        reply.data  = slot_data[hit_slot];
      end else begin
        reply.found = 1'b0;
        reply.data  = lkvc_pkg::MISS_DATA;
      end
      return 1'b1;
    end

    if (hit_slot >= 0) begin
      slot_data[hit_slot] = v;
      promote_slot(hit_slot);
    end else begin
      // When every slot is in use, the oldest entry is dropped first to make room.
      if (used_count >= ENTRIES) evict_oldest();
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_slot < 0 && !slot_used[i]) free_slot = i;
      end
      if (free_slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i]) slot_rank[i]++;
        end
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot]  = k;
        slot_data[free_slot] = v;
        slot_rank[free_slot] = 0;
        used_count++;
      end
    end

    // A capacity of zero acts as one, and a capacity above ENTRIES acts as ENTRIES.
    // Each put drops at most one entry, so a lowered capacity takes effect gradually.
    cap_eff = (cap_setting == 0) ? 1 : int'(cap_setting);
    if (cap_eff > ENTRIES) cap_eff = ENTRIES;
    if (used_count > cap_eff) evict_oldest();
    return 1'b0;
  endfunction

  // This offers one request and holds it until the block takes it. Valid is left high
  // after the transaction, so that a request that follows at once is offered without a
  // gap. A gap is made in the idle loop, or by wait_until_drained.
  task automatic send_request(input logic op, input logic [lkvc_pkg::KEY_W-1:0] req_key,
                              input logic [lkvc_pkg::DATA_W-1:0] req_data);
    cache_reply_t reply;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.key     <= req_key;
    in_if.data_in <= req_data;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    requests_sent++;
    if (op == lkvc_pkg::OP_GET) gets_sent++;
    if (predict_access(op, req_key, req_data, reply)) replies_due.push_back(reply);
  endtask

  // This waits until every reply has come back, and then waits out a put that may still
  // be in progress. After that the block is idle.
  task automatic wait_until_drained();
    in_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // This writes the capacity register. It is only called while the block is idle.
  task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] value);
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    cap_setting = value;
  endtask

  // This starts a new phase. The block is drained, the new capacity is written, and the
  // idle rates on both sides are chosen.
  task automatic begin_phase(input logic [lkvc_pkg::CAP_W-1:0] cap, input int snd_pct,
                             input int rcv_pct);
    wait_until_drained();
    write_capacity(cap);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
  endtask

  // This sends random gets and puts. Most keys come from the first pool_size pool
  // entries, so that hits, updates and evictions are frequent. About one key in ten is
  // a fresh random value, which almost always misses.
  task automatic drive_mixed_traffic(input int count, input int pool_size,
                                     input int put_pct);
    logic                       op;
    logic [lkvc_pkg::KEY_W-1:0] k;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(99) < put_pct) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET;
      k  = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(pool_size - 1)];
      send_request(op, k, $urandom);
    end
  endtask

  // These are the extreme keys and values. A get on an empty cache misses. The puts
  // insert new entries, a later put updates one of them, and the gets hit. At the end,
  // a key that was never stored misses.
  task automatic test_extreme_values();
    begin_phase(lkvc_pkg::CAP_RESET, 38, 69);
    send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h5A5A_5A5A);
    send_request(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h7FFF_FFFF);
    send_request(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h1234_5678);
    send_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(lkvc_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
  endtask

  // With a capacity of zero the cache behaves as if it held one entry. Updates to a key
  // that is present shrink the count by one each, until one entry is left. A new key then
  // pushes out the last of the old entries.
  task automatic test_capacity_zero();
    begin_phase('0, 38, 69);
    for (int n = 0; n < 4; n++) send_request(lkvc_pkg::OP_PUT, 32'h0000_0000, $urandom);
    send_request(lkvc_pkg::OP_PUT, 32'h0000_0005, 32'h0000_0037);
    send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(lkvc_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000);
  endtask

  // The largest capacity setting acts as ENTRIES. There are more pool keys than slots,
  // so the storage fills up and then evicts.
  task automatic test_capacity_above_entries();
    begin_phase('1, 38, 69);
    drive_mixed_traffic(300, 24, 50);
  endtask

  // The capacity is lowered while the cache is still full. The count then falls by at
  // most one per put.
  task automatic test_capacity_lowered();
    begin_phase(5'd3, 38, 69);
    drive_mixed_traffic(150, 8, 45);
  endtask

  task automatic test_single_entry();
    begin_phase(5'd1, 69, 38);
    drive_mixed_traffic(150, 4, 50);
  endtask

  // At exactly ENTRIES of capacity, a new key is inserted into full storage.
  task automatic test_full_storage();
    begin_phase(5'd16, 69, 38);
    drive_mixed_traffic(350, 20, 45);
  endtask

  task automatic test_mid_capacity();
    begin_phase(5'd8, 0, 0);
    drive_mixed_traffic(300, 12, 45);
  endtask

  // The reply side holds off for a long stretch while requests are still offered. The
  // reply register fills and the block stops taking new requests. Halfway through, the
  // sender waits until every reply has come before it goes on.
  task automatic test_output_stall();
    begin_phase(5'($urandom_range(17, 30)), 0, 0);
    @(negedge clk);
    result_hold = 600;
    @(posedge clk);
    drive_mixed_traffic(80, 16, 25);
    wait_until_drained();
    @(negedge clk);
    result_hold = 300;
    @(posedge clk);
    drive_mixed_traffic(80, 24, 40);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = lkvc_pkg::OP_GET;
    in_if.key       = '0;
    in_if.data_in   = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.capacity = lkvc_pkg::CAP_RESET;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    result_hold     = 0;
    error_count     = 0;
    requests_sent   = 0;
    gets_sent       = 0;
    replies_checked = 0;
    hits_seen       = 0;
    cycle_count     = 0;

    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_data[i] = '0;
      slot_rank[i] = 0;
    end
    used_count  = 0;
    cap_setting = lkvc_pkg::CAP_RESET;
    foreach (key_pool[i]) key_pool[i] = $urandom;

    // Reset is held low first. After that, the clearing pass runs until the block first
    // raises the ready signal of its request channel.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_values();
    test_capacity_zero();
    test_capacity_above_entries();
    test_capacity_lowered();
    test_single_entry();
    test_full_storage();
    test_mid_capacity();
    test_output_stall();

    wait_until_drained();
    $display("Sent %0d requests (%0d gets) at capacities 0, 1, 3, 8, 16, 31 and one above 16.",
             requests_sent, gets_sent);
    $display("Compared %0d replies, %0d of them hits, with long reply stalls included.",
             replies_checked, hits_seen);
    if (error_count == 0) begin
      $display("[lru_key_value_cache_unit] OK");
    end else begin
      $display("[lru_key_value_cache_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
